>>> rtl/dq_pkg.sv
package dq_pkg;

  localparam int WORD_W  = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       item_count;
  } dq_out_t;

endpackage

>>> rtl/dq_ram.sv
module dq_ram #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [$clog2(DEPTH)-1:0]              wr_addr,
  input  logic signed [dq_pkg::WORD_W-1:0]      wr_data,
  input  logic                                  rd_en,
  input  logic [$clog2(DEPTH)-1:0]              rd_addr,
  output logic signed [dq_pkg::WORD_W-1:0]      rd_data
);
  import dq_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words kept in a ring buffer.
//
// Input channel (in_valid / in_stall / in_data): one command per item:
// push front or back, pop front or back, peek front or back.
// Output channel (out_valid / out_stall / out_data): exactly one result item
// per command, in command order: the word read, a status and the count of
// stored words after the command.
//
// Pushes, failed pops or peeks and unused codes produce their result in the
// cycle after acceptance and may be issued every cycle while the receiver
// does not stall. A successful pop or peek reads the entry RAM, whose read
// port is registered, so its result passes through the RAM read register
// and then the output register; no new command is taken while it is pending.
//
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; entry RAM contents are not cleared, since no entry is read before
// it is written. While the receiver stalls, the result is held in the output
// register and in_stall rises, so no further command is taken until the
// result has been taken.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dq_pkg::dq_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dq_pkg::dq_out_t out_data
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // Queue pointers and occupancy
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // A RAM read is in flight; its result goes out next cycle
  logic               pend_r;
  logic [COUNT_W-1:0] pend_cnt_r;

  logic    out_valid_r;
  dq_out_t out_data_r;

  logic                accept;
  logic                is_empty, is_full;
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic signed [WORD_W-1:0] rd_data;
  logic [STAT_W-1:0]   imm_status;
  logic [CW+COUNT_W-1:0] count_ext;
  logic [COUNT_W-1:0]  count_out;

  // Hold off new commands while a read is pending or a result is stalled
  assign in_stall = !rst_n || pend_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == FULL_CNT);

  // Item count is reported masked to the field width
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};
  assign count_out = count_ext[COUNT_W-1:0];

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_addr    = tail_r;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    imm_status = ST_OK;
    if (accept) begin
      unique case (in_data.command)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (is_full) begin
            imm_status = ST_FULL;
          end else if (in_data.command == CMD_PUSH_FRONT) begin
            head_nxt  = ring_prev(head_r);
            wr_en     = 1'b1;
            wr_addr   = ring_prev(head_r);
            count_nxt = count_r + 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = tail_r;
            tail_nxt  = ring_next(tail_r);
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (is_empty) begin
            imm_status = ST_EMPTY;
          end else begin
            rd_en = 1'b1;
            if (in_data.command == CMD_POP_FRONT) begin
              rd_addr  = head_r;
              head_nxt = ring_next(head_r);
            end else begin
              rd_addr  = ring_prev(tail_r);
              tail_nxt = ring_prev(tail_r);
            end
            count_nxt = count_r - 1'b1;
            // Rewind both ends once the last word leaves
            if (count_r == CW'(1)) begin
              head_nxt = '0;
              tail_nxt = '0;
            end
          end
        end
        CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
          if (is_empty) begin
            imm_status = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = (in_data.command == CMD_PEEK_FRONT) ? head_r : ring_prev(tail_r);
          end
        end
        default: begin
          imm_status = ST_OK;
        end
      endcase
    end
  end

  dq_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      pend_r  <= rd_en;
      if ((accept && !rd_en) || pend_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: immediate results load at acceptance, read results once pend_r shows the RAM word is ready
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_cnt_r <= count_out;
    end
    if (pend_r) begin
      out_data_r <= '{read_value: rd_data, status: ST_OK, item_count: pend_cnt_r};
    end else if (accept && !rd_en) begin
      out_data_r <= '{read_value: '0, status: imm_status, item_count: count_out};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/dq_checker.sv
module dq_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input dq_pkg::dq_in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input dq_pkg::dq_out_t out_data
);
  import dq_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled command changed or vanished");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_EMPTY ||
                   out_data.status == ST_FULL))
    else $error("result carries an unknown status");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.read_value == '0)
    else $error("failed command returned a nonzero word");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall == !rst_n)
    else $error("output valid or input open right after reset");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
